FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and action codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	// command to the shared divider
	typedef struct packed {
		logic start;
	} div_ctl_t;

	// status back from the shared divider
	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage

FILE: rtl/rational_arith_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by its GCD.
// ----------------------------------------------------------------------------
// Input word on s_axis: action, a_num, a_den, b_num, b_den. Result word on
// m_axis: res_num, res_den, invalid. One result word per input word.
// The block takes one word at a time: s_axis_tready is high only when idle.
// Work: three products through one shared multiplier, a sum, then
// Euclid's loop where every remainder step runs the shared restoring
// divider, then two exact divides on the same divider. The run time
// depends on the number of Euclid steps, so on the operands; zero
// denominators skip the loop and the divides and answer invalid.
// Reset clears the sequencer and empties the output register.
// The result sits in the output register until m_axis_tready takes it; the
// next input word is accepted only after the result is taken.
// ----------------------------------------------------------------------------
module rational_arith_unit_core #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// action[1:0], a_num, a_den, b_num, b_den (W each), zero pad to bytes
	input  logic [((2+4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// res_num (2W+1), res_den (2W-1), zero pad to bytes
	output logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// invalid
	output logic m_axis_tuser
);
	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int NW = 2 * W + 1;
	localparam int DW = 2 * W - 1;
	localparam int IB = ((2 + 4 * W + 7) / 8) * 8;
	localparam int OB = ((4 * W + 7) / 8) * 8;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_M0   = 10'b0000000010,
		ST_M1   = 10'b0000000100,
		ST_M2   = 10'b0000001000,
		ST_M3   = 10'b0000010000,
		ST_SUM  = 10'b0000100000,
		ST_GCD  = 10'b0001000000,
		ST_DN   = 10'b0010000000,
		ST_DD   = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic          ans_q, ads_q, bns_q, bds_q;
	rau_pkg::action_t act_q;
	logic [PW-1:0] p0_q, p1_q, den_q;
	logic          p0s_q, p1s_q, dens_q;
	logic [NW-1:0] num_q;
	logic          nums_q;
	logic [NW-1:0] ga_q, gb_q;
	logic          dwait_q;
	logic [NW-1:0] nred_q;

	// shared multiplier
	logic [W-1:0]  mx, my;
	logic [PW-1:0] mp;
	assign mp = PW'(mx) * PW'(my);

	// shared divider
	rau_pkg::div_ctl_t dctl;
	rau_pkg::div_sts_t dsts;
	logic [NW-1:0] dvd, dvs, quot, rem;

	rau_div #(.W(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
		.sts(dsts), .quot(quot), .rem(rem)
	);

	logic [W-1:0] f_an, f_ad, f_bn, f_bd;
	assign f_an = s_axis_tdata[2 +: W];
	assign f_ad = s_axis_tdata[2 + W +: W];
	assign f_bn = s_axis_tdata[2 + 2 * W +: W];
	assign f_bd = s_axis_tdata[2 + 3 * W +: W];

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? W'(-v) : v;
	endfunction

	logic          out_v_q;
	logic [NW-1:0] rnum_q;
	logic [DW-1:0] rden_q;
	logic          rinv_q;
	logic          bneg_eff;
	logic          zero_den;
	logic [NW-1:0] sum_mag;
	logic          sum_neg;
	logic          neg_res;

	always_comb begin
		mx = an_q;
		my = bd_q;
		unique case (state_q)
			ST_M0:   begin mx = an_q; my = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q; end
			ST_M1:   begin mx = bn_q; my = ad_q; end
			ST_M2:   begin mx = ad_q; my = (act_q == rau_pkg::ACT_DIV) ? bn_q : bd_q; end
			default: begin mx = an_q; my = bd_q; end
		endcase
	end

	// sign of second cross term: subtract flips b_num
	assign bneg_eff = (act_q == rau_pkg::ACT_SUB) ? ~bns_q : bns_q;

	always_comb begin
		sum_mag = '0;
		sum_neg = 1'b0;
		if (p0s_q == p1s_q) begin
			sum_mag = NW'(p0_q) + NW'(p1_q);
			sum_neg = p0s_q;
		end else if (p0_q >= p1_q) begin
			sum_mag = NW'(p0_q - p1_q);
			sum_neg = p0s_q;
		end else begin
			sum_mag = NW'(p1_q - p0_q);
			sum_neg = p1s_q;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	assign zero_den = (ad_q == '0) || (bd_q == '0) || (den_q == '0);

	always_comb begin
		dctl.start = 1'b0;
		dvd = ga_q;
		dvs = gb_q;
		unique case (state_q)
			ST_GCD:  begin dctl.start = !dwait_q && (gb_q != '0); dvd = ga_q; dvs = gb_q; end
			ST_DN:   begin dctl.start = !dwait_q; dvd = num_q; dvs = ga_q; end
			ST_DD:   begin dctl.start = !dwait_q; dvd = NW'(den_q); dvs = ga_q; end
			default: begin dctl.start = 1'b0; dvd = ga_q; dvs = gb_q; end
		endcase
	end

	assign neg_res = (nred_q != '0) && (nums_q != dens_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dwait_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_q <= ST_M0;
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_SUM;
				ST_SUM: begin
					if (zero_den) begin
						state_q <= ST_IDLE;
						out_v_q <= 1'b1;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (dctl.start) dwait_q <= 1'b1;
					else if (dsts.done) dwait_q <= 1'b0;
					else if (!dwait_q && gb_q == '0) state_q <= ST_DN;
				end
				ST_DN: begin
					if (dctl.start) dwait_q <= 1'b1;
					else if (dsts.done) begin
						dwait_q <= 1'b0;
						state_q <= ST_DD;
					end
				end
				ST_DD: begin
					if (dctl.start) dwait_q <= 1'b1;
					else if (dsts.done) begin
						dwait_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
					out_v_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				act_q <= rau_pkg::action_t'(s_axis_tdata[1:0]);
				an_q  <= mag_of(f_an);  ans_q <= f_an[W-1];
				ad_q  <= mag_of(f_ad);  ads_q <= f_ad[W-1];
				bn_q  <= mag_of(f_bn);  bns_q <= f_bn[W-1];
				bd_q  <= mag_of(f_bd);  bds_q <= f_bd[W-1];
			end
			ST_M0: begin
				p0_q  <= mp;
				p0s_q <= (mp != '0) &&
					(ans_q != ((act_q == rau_pkg::ACT_MUL) ? bns_q : bds_q));
			end
			ST_M1: begin
				p1_q  <= mp;
				p1s_q <= (mp != '0) && (bneg_eff != ads_q);
			end
			ST_M2: begin
				den_q  <= mp;
				dens_q <= (mp != '0) &&
					(ads_q != ((act_q == rau_pkg::ACT_DIV) ? bns_q : bds_q));
			end
			ST_M3: begin
				if (act_q == rau_pkg::ACT_MUL || act_q == rau_pkg::ACT_DIV) begin
					num_q  <= NW'(p0_q);
					nums_q <= p0s_q;
				end else begin
					num_q  <= sum_mag;
					nums_q <= sum_neg;
				end
			end
			ST_SUM: begin
				ga_q   <= num_q;
				gb_q   <= NW'(den_q);
				rnum_q <= '0;
				rden_q <= '0;
				rinv_q <= 1'b1;
			end
			ST_GCD: if (dsts.done) begin
				ga_q <= gb_q;
				gb_q <= rem;
			end
			ST_DN: if (dsts.done) nred_q <= quot;
			ST_DD: if (dsts.done) rden_q <= DW'(quot);
			ST_OUT: begin
				rnum_q <= neg_res ? NW'(-nred_q) : nred_q;
				rinv_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OB'({rden_q, rnum_q});
	assign m_axis_tuser  = rinv_q;

	logic unused_pad;
	assign unused_pad = ^s_axis_tdata[IB-1:2+4*W];
endmodule

FILE: rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
	parameter int W = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rau_pkg::div_ctl_t ctl,
	input  logic [W-1:0]      dividend,
	input  logic [W-1:0]      divisor,
	output rau_pkg::div_sts_t sts,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {r_q, q_q[W-1]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= shifted[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign quot     = q_q;
	assign rem      = r_q;
endmodule
